[hdl/rmst_pkg.sv]
// Shared types and constants for the range-maximum segment tree.
package rmst_pkg;

	localparam int LEAF_COUNT_DEF = 1024;
	localparam int VALUE_BITS_DEF = 32;
	localparam int POS_W          = 11;
	localparam int LEN_W          = 11;
	localparam int DATA_W         = 32;
	localparam int IN_TDATA_W     = 72;
	localparam int OUT_TDATA_W    = 32;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CMD,
		ST_LEAF,
		ST_URD,
		ST_UWR,
		ST_QSTEP,
		ST_QL,
		ST_QR,
		ST_QDONE
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,
		OP_ACCEPT,
		OP_LEAF,
		OP_URD,
		OP_UWR,
		OP_QSTEP,
		OP_QL,
		OP_QR,
		OP_OUT
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_last;
		logic is_query;
		logic q_empty;
		logic load_ok;
		logic up_more;
		logic up_next;
		logic l_lt_r;
		logic l_odd;
		logic r_odd;
		logic out_free;
	} dp_status_t;

endpackage

[hdl/rmst_ctrl.sv]
// Controller state machine sequencing clear, load and query walks.
module rmst_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  rmst_pkg::dp_status_t status,
	output rmst_pkg::dp_cmd_t    cmd
);

	rmst_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rmst_pkg::ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.op   = rmst_pkg::OP_NONE;
		s_tready = 1'b0;
		unique case (state_q)
			rmst_pkg::ST_CLEAR: begin
				cmd.op = rmst_pkg::OP_CLEAR;
				if (status.clear_last) state_d = rmst_pkg::ST_IDLE;
			end
			rmst_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.op  = rmst_pkg::OP_ACCEPT;
					state_d = rmst_pkg::ST_CMD;
				end
			end
			rmst_pkg::ST_CMD: begin
				if (status.is_query) begin
					state_d = status.q_empty ? rmst_pkg::ST_QDONE : rmst_pkg::ST_QSTEP;
				end else begin
					state_d = status.load_ok ? rmst_pkg::ST_LEAF : rmst_pkg::ST_IDLE;
				end
			end
			rmst_pkg::ST_LEAF: begin
				cmd.op  = rmst_pkg::OP_LEAF;
				state_d = status.up_more ? rmst_pkg::ST_URD : rmst_pkg::ST_IDLE;
			end
			rmst_pkg::ST_URD: begin
				cmd.op  = rmst_pkg::OP_URD;
				state_d = rmst_pkg::ST_UWR;
			end
			rmst_pkg::ST_UWR: begin
				cmd.op  = rmst_pkg::OP_UWR;
				state_d = status.up_next ? rmst_pkg::ST_URD : rmst_pkg::ST_IDLE;
			end
			rmst_pkg::ST_QSTEP: begin
				if (!status.l_lt_r) begin
					state_d = rmst_pkg::ST_QDONE;
				end else begin
					cmd.op = rmst_pkg::OP_QSTEP;
					priority if (status.l_odd) state_d = rmst_pkg::ST_QL;
					else if (status.r_odd)     state_d = rmst_pkg::ST_QR;
					else                       state_d = rmst_pkg::ST_QSTEP;
				end
			end
			rmst_pkg::ST_QL: begin
				cmd.op  = rmst_pkg::OP_QL;
				state_d = status.r_odd ? rmst_pkg::ST_QR : rmst_pkg::ST_QSTEP;
			end
			rmst_pkg::ST_QR: begin
				cmd.op  = rmst_pkg::OP_QR;
				state_d = rmst_pkg::ST_QSTEP;
			end
			rmst_pkg::ST_QDONE: begin
				if (status.out_free) begin
					cmd.op  = rmst_pkg::OP_OUT;
					state_d = rmst_pkg::ST_IDLE;
				end
			end
			default: state_d = rmst_pkg::ST_CLEAR;
		endcase
	end

endmodule

[hdl/rmst_dp.sv]
// Datapath: node memory, walk indices, running maxima and output register.
module rmst_dp #(
	parameter int LEAF_COUNT = rmst_pkg::LEAF_COUNT_DEF,
	parameter int VALUE_BITS = rmst_pkg::VALUE_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  rmst_pkg::dp_cmd_t            cmd,
	output rmst_pkg::dp_status_t         status,
	input  logic                         cfg_we,
	input  logic [rmst_pkg::LEN_W-1:0]   cfg_wdata,
	input  logic                         command,
	input  logic [rmst_pkg::POS_W-1:0]   position,
	input  logic [rmst_pkg::DATA_W-1:0]  element_value,
	input  logic [rmst_pkg::POS_W-1:0]   range_low,
	input  logic [rmst_pkg::POS_W-1:0]   range_high,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [rmst_pkg::DATA_W-1:0]  max_value,
	output logic                         range_empty
);

	localparam int AW = $clog2(2 * LEAF_COUNT);
	localparam int IW = $clog2(2 * LEAF_COUNT + 1);
	localparam int LW = (IW > rmst_pkg::POS_W) ? IW : rmst_pkg::POS_W;
	localparam logic [IW-1:0] NODES   = IW'(2 * LEAF_COUNT);
	localparam logic [LW-1:0] LEAVES  = LW'(LEAF_COUNT);

	logic [VALUE_BITS-1:0] mem [2 * LEAF_COUNT];

	logic [IW-1:0]         clr_q;
	logic [LW-1:0]         used_q;
	logic                  out_valid_q;
	logic [VALUE_BITS-1:0] rdata_q;
	logic [IW-1:0]         i_q, l_q, r_q;
	logic [VALUE_BITS-1:0] cur_q, best_q;
	logic                  is_query_q, empty_q, load_ok_q;
	logic [rmst_pkg::DATA_W-1:0] max_q;
	logic                  range_empty_q;

	logic                  rd_en, wr_en;
	logic [AW-1:0]         raddr, waddr;
	logic [VALUE_BITS-1:0] wdata;
	logic [IW-1:0]         r_m1, i_up;
	logic [VALUE_BITS-1:0] upd_max, best_mx, val_trunc;
	logic [rmst_pkg::DATA_W+VALUE_BITS-1:0] val_ext, best_ext;
	logic [LW-1:0]         pos_w, lo_w, hi_w, len_eff, leaf_w, l_w, r_w;
	logic                  pos_ok, q_empty;

	assign r_m1    = r_q - IW'(1);
	assign i_up    = i_q >> 1;
	assign upd_max = (cur_q > rdata_q) ? cur_q : rdata_q;
	assign best_mx = (best_q > rdata_q) ? best_q : rdata_q;

	assign val_ext   = {{VALUE_BITS{1'b0}}, element_value};
	assign val_trunc = val_ext[VALUE_BITS-1:0];
	assign best_ext  = {{rmst_pkg::DATA_W{1'b0}}, best_q};

	always_comb begin
		pos_w   = LW'(position);
		pos_ok  = (pos_w != '0) && (pos_w <= LEAVES);
		leaf_w  = LEAVES + pos_w - LW'(1);
		len_eff = (used_q < LEAVES) ? used_q : LEAVES;
		lo_w    = (range_low == '0) ? LW'(1) : LW'(range_low);
		hi_w    = (LW'(range_high) > len_eff) ? len_eff : LW'(range_high);
		q_empty = lo_w > hi_w;
		l_w     = LEAVES + lo_w - LW'(1);
		r_w     = LEAVES + hi_w;
	end

	always_comb begin
		rd_en = 1'b0;
		wr_en = 1'b0;
		raddr = '0;
		waddr = '0;
		wdata = '0;
		unique case (cmd.op)
			rmst_pkg::OP_CLEAR: begin
				wr_en = 1'b1;
				waddr = clr_q[AW-1:0];
			end
			rmst_pkg::OP_LEAF: begin
				wr_en = 1'b1;
				waddr = i_q[AW-1:0];
				wdata = cur_q;
			end
			rmst_pkg::OP_URD: begin
				rd_en = 1'b1;
				raddr = {i_q[AW-1:1], ~i_q[0]};
			end
			rmst_pkg::OP_UWR: begin
				wr_en = 1'b1;
				waddr = i_up[AW-1:0];
				wdata = upd_max;
			end
			rmst_pkg::OP_QSTEP: begin
				priority if (l_q[0]) begin
					rd_en = 1'b1;
					raddr = l_q[AW-1:0];
				end else if (r_q[0]) begin
					rd_en = 1'b1;
					raddr = r_m1[AW-1:0];
				end
			end
			rmst_pkg::OP_QL: begin
				if (r_q[0]) begin
					rd_en = 1'b1;
					raddr = r_m1[AW-1:0];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[waddr] <= wdata;
		if (rd_en) rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			used_q      <= LEAVES;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == rmst_pkg::OP_CLEAR) clr_q <= clr_q + IW'(1);
			if (cfg_we) used_q <= LW'(cfg_wdata);
			if (cmd.op == rmst_pkg::OP_OUT) out_valid_q <= 1'b1;
			else if (out_ready)             out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			rmst_pkg::OP_ACCEPT: begin
				is_query_q <= command;
				load_ok_q  <= pos_ok;
				empty_q    <= q_empty;
				i_q        <= leaf_w[IW-1:0];
				cur_q      <= val_trunc;
				l_q        <= l_w[IW-1:0];
				r_q        <= r_w[IW-1:0];
				best_q     <= '0;
			end
			rmst_pkg::OP_UWR: begin
				cur_q <= upd_max;
				i_q   <= i_up;
			end
			rmst_pkg::OP_QSTEP: begin
				priority if (l_q[0]) begin
					l_q <= l_q + IW'(1);
				end else if (r_q[0]) begin
					r_q <= r_m1;
				end else begin
					l_q <= l_q >> 1;
					r_q <= r_q >> 1;
				end
			end
			rmst_pkg::OP_QL: begin
				best_q <= best_mx;
				if (r_q[0]) begin
					r_q <= r_m1;
				end else begin
					l_q <= l_q >> 1;
					r_q <= r_q >> 1;
				end
			end
			rmst_pkg::OP_QR: begin
				best_q <= best_mx;
				l_q    <= l_q >> 1;
				r_q    <= r_q >> 1;
			end
			rmst_pkg::OP_OUT: begin
				max_q         <= best_ext[rmst_pkg::DATA_W-1:0];
				range_empty_q <= empty_q;
			end
			default: ;
		endcase
	end

	assign status.clear_last = (clr_q == NODES - IW'(1));
	assign status.is_query   = is_query_q;
	assign status.q_empty    = empty_q;
	assign status.load_ok    = load_ok_q;
	assign status.up_more    = (i_q > IW'(1));
	assign status.up_next    = (i_up > IW'(1));
	assign status.l_lt_r     = (l_q < r_q);
	assign status.l_odd      = l_q[0];
	assign status.r_odd      = r_q[0];
	assign status.out_free   = !out_valid_q || out_ready;

	assign out_valid   = out_valid_q;
	assign max_value   = max_q;
	assign range_empty = range_empty_q;

	a_walk_order: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == rmst_pkg::OP_QSTEP || cmd.op == rmst_pkg::OP_QL ||
		 cmd.op == rmst_pkg::OP_QR) |-> (l_q <= r_q))
		else $error("query walk crossed: left index above right");

	a_parent_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == rmst_pkg::OP_UWR) |-> (i_q > IW'(1)))
		else $error("update walk wrote above the root");

	a_valid_from_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(cmd.op == rmst_pkg::OP_OUT))
		else $error("output word raised without a finished query");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == rmst_pkg::OP_OUT && empty_q) |-> (best_q == '0))
		else $error("empty range carries a nonzero maximum");

endmodule

[hdl/range_max_segment_tree_top.sv]
// Top level of the range-maximum segment tree with stream ports.
// After reset the node memory is cleared, one node a cycle, over all
// 2*LEAF_COUNT entries (2048 at the default), and no word is accepted during
// that pass. Items are then taken one at a time through a single-port node
// memory with registered read data. A load captures the word, decodes it,
// writes the leaf, then does a sibling read and a parent write per level up
// to the root. A load to a position of 0 or beyond LEAF_COUNT is dropped at
// decode. A query captures and decodes the word, walks the tree level by
// level with an extra step for each node folded into the maximum, and then
// loads the result; an empty range goes from decode straight to the result.
// The result word sits in an output register, so the block returns to accept
// the next word once it has been loaded there. The length register must be
// written through cfg_we and cfg_wdata only while the block is idle; the
// block itself does not enforce this.
module range_max_segment_tree_top #(
	parameter int LEAF_COUNT = rmst_pkg::LEAF_COUNT_DEF,
	parameter int VALUE_BITS = rmst_pkg::VALUE_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rmst_pkg::LEN_W-1:0]        cfg_wdata,   // used_length
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// position[10:0], element_value[42:11], range_low[53:43], range_high[64:54]
	input  logic [rmst_pkg::IN_TDATA_W-1:0]   s_tdata,
	input  logic                              s_tuser,     // command
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [rmst_pkg::OUT_TDATA_W-1:0]  m_tdata,     // max_value[31:0]
	output logic                              m_tuser      // range_empty
);

	rmst_pkg::dp_cmd_t    cmd;
	rmst_pkg::dp_status_t status;

	rmst_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	rmst_dp #(
		.LEAF_COUNT (LEAF_COUNT),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.command       (s_tuser),
		.position      (s_tdata[10:0]),
		.element_value (s_tdata[42:11]),
		.range_low     (s_tdata[53:43]),
		.range_high    (s_tdata[64:54]),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.max_value     (m_tdata),
		.range_empty   (m_tuser)
	);

endmodule
